[rtl/flgb_pkg.sv]
// ----------------------------------------------------------------------------
// flgb_pkg
// Shared constants, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package flgb_pkg;

   localparam int FLGB_COORD_WIDTH = 12;
   localparam int FLGB_FRAC_BITS   = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 16;

   // tan(30 deg) in Q16: the eye line stays within 30 deg of horizontal
   localparam int TAN_W     = 16;
   localparam int Q16_SHIFT = 16;
   localparam logic [TAN_W-1:0] TAN30_Q16 = 16'd37837;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [BYTE_W-1:0]  ETW_RESET  = 8'd16;
   localparam logic [BYTE_W-1:0]  THR_RESET  = 8'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_LEFT_EYE_X  = 3'd0,
      CSR_REF_LEFT_EYE_Y  = 3'd1,
      CSR_REF_RIGHT_EYE_X = 3'd2,
      CSR_REF_RIGHT_EYE_Y = 3'd3,
      CSR_REF_NOSE_X      = 3'd4,
      CSR_REF_NOSE_Y      = 3'd5,
      CSR_EYE_TMPL_WIDTH  = 3'd6,
      CSR_BLINK_THRESHOLD = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_WAIT,
      ST_FIN
   } state_type;

   // vector being measured: right gaze, left gaze, tracked eyes, reference eyes
   typedef enum logic [1:0] {
      VEC_GAZE_RIGHT = 2'd0,
      VEC_GAZE_LEFT  = 2'd1,
      VEC_EYES_TRK   = 2'd2,
      VEC_EYES_REF   = 2'd3
   } vec_type;

   typedef struct packed {
      logic    load;
      logic    prep;
      logic    sq_x;
      logic    sq_y;
      logic    root_start;
      logic    root_store;
      logic    commit;
      vec_type vec;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[rtl/flgb_if.sv]
// ----------------------------------------------------------------------------
// flgb channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface flgb_req_if #(
   parameter int COORD_WIDTH = 12
);
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] left_eye_x;
   logic [COORD_WIDTH-1:0] left_eye_y;
   logic [COORD_WIDTH-1:0] right_eye_x;
   logic [COORD_WIDTH-1:0] right_eye_y;
   logic [COORD_WIDTH-1:0] nose_x;
   logic [COORD_WIDTH-1:0] nose_y;
   logic [COORD_WIDTH-1:0] mouth_x;
   logic [COORD_WIDTH-1:0] mouth_y;

   modport source (
      output valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
             nose_x, nose_y, mouth_x, mouth_y,
      input  ready
   );
   modport sink (
      input  valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y,
             nose_x, nose_y, mouth_x, mouth_y,
      output ready
   );
endinterface

interface flgb_rsp_if #(
   parameter int COORD_WIDTH = 12
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH+1:0] gaze_right_x;
   logic signed [COORD_WIDTH+1:0] gaze_right_y;
   logic signed [COORD_WIDTH+1:0] gaze_left_x;
   logic signed [COORD_WIDTH+1:0] gaze_left_y;
   logic [COORD_WIDTH+1:0]        right_magnitude;
   logic [COORD_WIDTH+1:0]        left_magnitude;
   logic [15:0]                   right_blinks;
   logic [15:0]                   left_blinks;
   logic                          eyes_ok;
   logic                          nose_ok;
   logic                          mouth_ok;

   modport source (
      output valid, gaze_right_x, gaze_right_y, gaze_left_x, gaze_left_y,
             right_magnitude, left_magnitude, right_blinks, left_blinks,
             eyes_ok, nose_ok, mouth_ok,
      input  ready
   );
   modport sink (
      input  valid, gaze_right_x, gaze_right_y, gaze_left_x, gaze_left_y,
             right_magnitude, left_magnitude, right_blinks, left_blinks,
             eyes_ok, nose_ok, mouth_ok,
      output ready
   );
endinterface

interface flgb_csr_if #(
   parameter int INDEX_W = 3,
   parameter int DATA_W  = 12
);
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/flgb_sqrt.sv]
// ----------------------------------------------------------------------------
// flgb_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module flgb_sqrt #(
   parameter int RAD_W = 34
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RAD_W-1:0]   radicand,
   output logic                    done,
   output logic [RAD_W/2-1:0]      root
);

   localparam int RT_W  = RAD_W / 2;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [RAD_W-1:0] rad_ff,  rad_in;
   logic [RT_W+1:0]  rem_ff,  rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [RT_W+1:0]  rem_sh;
   logic [RT_W+1:0]  trial;
   logic             fits;

   always_comb begin
      rem_sh  = {rem_ff[RT_W-1:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1)) && !start;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[RT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

[rtl/flgb_dp.sv]
// ----------------------------------------------------------------------------
// flgb_dp
// Datapath: registers, gaze vectors, shared squarer, root unit, blink
// counters, plausibility flags and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flgb_dp
   import flgb_pkg::*;
#(
   parameter int COORD_WIDTH = FLGB_COORD_WIDTH,
   parameter int FRAC_BITS   = FLGB_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output sts_type                            sts,
   input  wire logic                          csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [COORD_WIDTH-1:0]        csr_data,
   input  wire logic [COORD_WIDTH-1:0]        left_eye_x,
   input  wire logic [COORD_WIDTH-1:0]        left_eye_y,
   input  wire logic [COORD_WIDTH-1:0]        right_eye_x,
   input  wire logic [COORD_WIDTH-1:0]        right_eye_y,
   input  wire logic [COORD_WIDTH-1:0]        nose_x,
   input  wire logic [COORD_WIDTH-1:0]        nose_y,
   input  wire logic [COORD_WIDTH-1:0]        mouth_x,
   input  wire logic [COORD_WIDTH-1:0]        mouth_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [COORD_WIDTH+1:0]      gaze_right_x,
   output logic signed [COORD_WIDTH+1:0]      gaze_right_y,
   output logic signed [COORD_WIDTH+1:0]      gaze_left_x,
   output logic signed [COORD_WIDTH+1:0]      gaze_left_y,
   output logic [COORD_WIDTH+1:0]             right_magnitude,
   output logic [COORD_WIDTH+1:0]             left_magnitude,
   output logic [COUNT_W-1:0]                 right_blinks,
   output logic [COUNT_W-1:0]                 left_blinks,
   output logic                               eyes_ok,
   output logic                               nose_ok,
   output logic                               mouth_ok
);

   localparam int CW    = COORD_WIDTH;
   localparam int GW    = CW + 2;
   localparam int MW    = CW + 1;
   localparam int PW    = 2 * MW;
   localparam int SW    = PW + 1;
   localparam int FX    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int RAD_W = 2 * CW + 2 + 2 * FX;
   localparam int RT_W  = RAD_W / 2;
   localparam int DW    = CW + 1 + FRAC_BITS;
   localparam int CMPW  = DW + 1;
   localparam int AW    = CW + TAN_W;

   // registers
   logic [CW-1:0]     ref_lx_ff, ref_ly_ff, ref_rx_ff, ref_ry_ff, ref_nx_ff, ref_ny_ff;
   logic [BYTE_W-1:0] etw_ff, thr_ff;

   // latched item
   logic [CW-1:0] lx_ff, ly_ff, rx_ff, ry_ff, nx_ff, ny_ff, mx_ff, my_ff;

   // vectors
   logic signed [GW-1:0] grx_ff, gry_ff, glx_ff, gly_ff;
   logic signed [CW:0]   tdx_ff, tdy_ff, rdx_ff, rdy_ff;
   logic signed [GW-1:0] grx_in, gry_in, glx_in, gly_in;
   logic signed [CW:0]   tdx_in, tdy_in, rdx_in, rdy_in;
   logic signed [CW:0]   ndx, ndy, olx, oly, orx, ory;

   // squarer and root
   logic signed [GW-1:0] opx, opy, op, op_neg;
   logic [MW-1:0]        op_mag;
   logic [PW-1:0]        prod_ff, px_ff, prod_in;
   logic [SW-1:0]        rad_sum;
   logic [RAD_W-1:0]     radicand;
   logic                 root_done;
   logic [RT_W-1:0]      root;

   logic [GW-1:0] rmag_ff, lmag_ff;
   logic [DW-1:0] dt_ff, dr_ff;

   // angle
   logic [CW-1:0] tdx_pos, abs_dy;
   logic [CW:0]   tdy_neg;
   logic [AW-1:0] ang_prod_ff, ang_lhs;
   logic          ang_ok, dist_ok;
   logic [CMPW-1:0] dt_e, dr_e, w_e;

   // blink state doubles as the magnitude and count fields of the result
   logic [GW-1:0]      prev_r_ff, prev_l_ff, diff_r, diff_l;
   logic [COUNT_W-1:0] cnt_r_ff, cnt_l_ff, cnt_r_in, cnt_l_in;
   logic               blink_r, blink_l;

   logic signed [GW-1:0] out_grx_ff, out_gry_ff, out_glx_ff, out_gly_ff;
   logic                 out_eyes_ff, out_nose_ff, out_mouth_ff;
   logic                 rsp_valid_ff;
   logic                 nose_in, mouth_in;

   // ---- register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_lx_ff <= '0;
         ref_ly_ff <= '0;
         ref_rx_ff <= '0;
         ref_ry_ff <= '0;
         ref_nx_ff <= '0;
         ref_ny_ff <= '0;
         etw_ff    <= ETW_RESET;
         thr_ff    <= THR_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_REF_LEFT_EYE_X:  ref_lx_ff <= csr_data;
            CSR_REF_LEFT_EYE_Y:  ref_ly_ff <= csr_data;
            CSR_REF_RIGHT_EYE_X: ref_rx_ff <= csr_data;
            CSR_REF_RIGHT_EYE_Y: ref_ry_ff <= csr_data;
            CSR_REF_NOSE_X:      ref_nx_ff <= csr_data;
            CSR_REF_NOSE_Y:      ref_ny_ff <= csr_data;
            CSR_EYE_TMPL_WIDTH:  etw_ff    <= csr_data[BYTE_W-1:0];
            CSR_BLINK_THRESHOLD: thr_ff    <= csr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- item latch
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lx_ff <= left_eye_x;
         ly_ff <= left_eye_y;
         rx_ff <= right_eye_x;
         ry_ff <= right_eye_y;
         nx_ff <= nose_x;
         ny_ff <= nose_y;
         mx_ff <= mouth_x;
         my_ff <= mouth_y;
      end
   end

   // ---- gaze and eye-line vectors
   always_comb begin
      ndx = $signed({1'b0, nx_ff}) - $signed({1'b0, ref_nx_ff});
      ndy = $signed({1'b0, ny_ff}) - $signed({1'b0, ref_ny_ff});
      orx = $signed({1'b0, rx_ff}) - $signed({1'b0, ref_rx_ff});
      ory = $signed({1'b0, ry_ff}) - $signed({1'b0, ref_ry_ff});
      olx = $signed({1'b0, lx_ff}) - $signed({1'b0, ref_lx_ff});
      oly = $signed({1'b0, ly_ff}) - $signed({1'b0, ref_ly_ff});
      // y is flipped so that up counts positive
      grx_in = $signed({orx[CW], orx}) - $signed({ndx[CW], ndx});
      gry_in = $signed({ndy[CW], ndy}) - $signed({ory[CW], ory});
      glx_in = $signed({olx[CW], olx}) - $signed({ndx[CW], ndx});
      gly_in = $signed({ndy[CW], ndy}) - $signed({oly[CW], oly});
      tdx_in = $signed({1'b0, rx_ff}) - $signed({1'b0, lx_ff});
      tdy_in = $signed({1'b0, ry_ff}) - $signed({1'b0, ly_ff});
      rdx_in = $signed({1'b0, ref_rx_ff}) - $signed({1'b0, ref_lx_ff});
      rdy_in = $signed({1'b0, ref_ry_ff}) - $signed({1'b0, ref_ly_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         grx_ff <= grx_in;
         gry_ff <= gry_in;
         glx_ff <= glx_in;
         gly_ff <= gly_in;
         tdx_ff <= tdx_in;
         tdy_ff <= tdy_in;
         rdx_ff <= rdx_in;
         rdy_ff <= rdy_in;
      end
   end

   // ---- shared squarer
   always_comb begin
      case (cmd.vec)
         VEC_GAZE_RIGHT: begin
            opx = grx_ff;
            opy = gry_ff;
         end
         VEC_GAZE_LEFT: begin
            opx = glx_ff;
            opy = gly_ff;
         end
         VEC_EYES_TRK: begin
            opx = $signed({tdx_ff[CW], tdx_ff});
            opy = $signed({tdy_ff[CW], tdy_ff});
         end
         default: begin
            opx = $signed({rdx_ff[CW], rdx_ff});
            opy = $signed({rdy_ff[CW], rdy_ff});
         end
      endcase
      op      = cmd.sq_y ? opy : opx;
      op_neg  = -op;
      op_mag  = op[GW-1] ? op_neg[MW-1:0] : op[MW-1:0];
      prod_in = PW'(op_mag) * PW'(op_mag);
      rad_sum = SW'(px_ff) + SW'(prod_ff);
      // eye distances carry fraction bits: scale the radicand by 4^FRAC_BITS
      if (cmd.vec == VEC_EYES_TRK || cmd.vec == VEC_EYES_REF) begin
         radicand = RAD_W'(rad_sum) << (2 * FRAC_BITS);
      end else begin
         radicand = RAD_W'(rad_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_x || cmd.sq_y) begin
         prod_ff <= prod_in;
      end
      if (cmd.sq_y) begin
         px_ff <= prod_ff;
      end
   end

   flgb_sqrt #(
      .RAD_W (RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.root_store) begin
         case (cmd.vec)
            VEC_GAZE_RIGHT: rmag_ff <= root[GW-1:0];
            VEC_GAZE_LEFT:  lmag_ff <= root[GW-1:0];
            VEC_EYES_TRK:   dt_ff   <= root[DW-1:0];
            default:        dr_ff   <= root[DW-1:0];
         endcase
      end
   end

   // ---- eye angle: |dy| * 2^16 < dx * tan30_q16, never true for dx <= 0
   always_comb begin
      tdx_pos = tdx_ff[CW] ? '0 : tdx_ff[CW-1:0];
      tdy_neg = -tdy_ff;
      abs_dy  = tdy_ff[CW] ? tdy_neg[CW-1:0] : tdy_ff[CW-1:0];
      ang_lhs = AW'(abs_dy) << Q16_SHIFT;
      ang_ok  = (ang_lhs < ang_prod_ff);
   end

   always_ff @(posedge clock) begin
      ang_prod_ff <= AW'(tdx_pos) * AW'(TAN30_Q16);
   end

   // ---- eye distance within reference +/- template width
   always_comb begin
      dt_e    = CMPW'(dt_ff);
      dr_e    = CMPW'(dr_ff);
      w_e     = CMPW'(etw_ff) << FRAC_BITS;
      dist_ok = ((dt_e + w_e) > dr_e) && (dt_e < (dr_e + w_e));
      nose_in  = (nx_ff < rx_ff) && (nx_ff > lx_ff) && (ny_ff > ry_ff) && (ny_ff > ly_ff);
      mouth_in = (mx_ff < rx_ff) && (mx_ff > lx_ff) && (my_ff > ry_ff) && (my_ff > ly_ff);
   end

   // ---- blink counting
   always_comb begin
      diff_r   = (prev_r_ff > rmag_ff) ? (prev_r_ff - rmag_ff) : (rmag_ff - prev_r_ff);
      diff_l   = (prev_l_ff > lmag_ff) ? (prev_l_ff - lmag_ff) : (lmag_ff - prev_l_ff);
      blink_r  = (diff_r >= GW'(thr_ff));
      blink_l  = (diff_l >= GW'(thr_ff));
      cnt_r_in = (blink_r && cnt_r_ff != COUNT_MAX) ? cnt_r_ff + COUNT_W'(1) : cnt_r_ff;
      cnt_l_in = (blink_l && cnt_l_ff != COUNT_MAX) ? cnt_l_ff + COUNT_W'(1) : cnt_l_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_r_ff    <= '0;
         prev_l_ff    <= '0;
         cnt_r_ff     <= '0;
         cnt_l_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            prev_r_ff    <= rmag_ff;
            prev_l_ff    <= lmag_ff;
            cnt_r_ff     <= cnt_r_in;
            cnt_l_ff     <= cnt_l_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_grx_ff   <= grx_ff;
         out_gry_ff   <= gry_ff;
         out_glx_ff   <= glx_ff;
         out_gly_ff   <= gly_ff;
         out_eyes_ff  <= ang_ok && dist_ok;
         out_nose_ff  <= nose_in;
         out_mouth_ff <= mouth_in;
      end
   end

   assign sts.root_done = root_done;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign gaze_right_x    = out_grx_ff;
   assign gaze_right_y    = out_gry_ff;
   assign gaze_left_x     = out_glx_ff;
   assign gaze_left_y     = out_gly_ff;
   assign right_magnitude = prev_r_ff;
   assign left_magnitude  = prev_l_ff;
   assign right_blinks    = cnt_r_ff;
   assign left_blinks     = cnt_l_ff;
   assign eyes_ok         = out_eyes_ff;
   assign nose_ok         = out_nose_ff;
   assign mouth_ok        = out_mouth_ff;

endmodule

`default_nettype wire

[rtl/flgb_ctrl.sv]
// ----------------------------------------------------------------------------
// flgb_ctrl
// Sequencer: latch an item, square and root four vectors in turn, then
// commit the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flgb_ctrl
   import flgb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   vec_type   vec_ff,   vec_in;

   // next state
   always_comb begin
      state_in = state_ff;
      vec_in   = vec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_SQ_X;
            vec_in   = VEC_GAZE_RIGHT;
         end
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_ROOT;
         ST_ROOT: state_in = ST_WAIT;
         ST_WAIT: begin
            if (sts.root_done) begin
               if (vec_ff == VEC_EYES_REF) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SQ_X;
                  vec_in   = vec_type'(vec_ff + 2'd1);
               end
            end
         end
         ST_FIN: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.vec   = vec_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PREP: cmd.prep       = 1'b1;
         ST_SQ_X: cmd.sq_x       = 1'b1;
         ST_SQ_Y: cmd.sq_y       = 1'b1;
         ST_ROOT: cmd.root_start = 1'b1;
         ST_WAIT: cmd.root_store = sts.root_done;
         ST_FIN:  cmd.commit     = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vec_ff   <= VEC_GAZE_RIGHT;
      end else begin
         state_ff <= state_in;
         vec_ff   <= vec_in;
      end
   end

endmodule

`default_nettype wire

[rtl/face_landmark_gaze_blink_check.sv]
// ----------------------------------------------------------------------------
// face_landmark_gaze_blink_check
// Sequencing: one item at a time, through the single shared bit-per-cycle
//   square root unit, which takes four roots per item, each of
//   COORD_WIDTH + 1 + max(FRAC_BITS,1) root bits. A held result does not stop
//   the next item being accepted; its commit waits for the held result.
// Reset: synchronous; clears blink counters, previous magnitudes and register
//   file to its reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module face_landmark_gaze_blink_check
   import flgb_pkg::*;
#(
   parameter int COORD_WIDTH = FLGB_COORD_WIDTH,
   parameter int FRAC_BITS   = FLGB_FRAC_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   flgb_req_if.sink   req_ch,
   flgb_rsp_if.source rsp_ch,
   flgb_csr_if.sink   csr_ch
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   flgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   flgb_dp #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .left_eye_x      (req_ch.left_eye_x),
      .left_eye_y      (req_ch.left_eye_y),
      .right_eye_x     (req_ch.right_eye_x),
      .right_eye_y     (req_ch.right_eye_y),
      .nose_x          (req_ch.nose_x),
      .nose_y          (req_ch.nose_y),
      .mouth_x         (req_ch.mouth_x),
      .mouth_y         (req_ch.mouth_y),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .gaze_right_x    (rsp_ch.gaze_right_x),
      .gaze_right_y    (rsp_ch.gaze_right_y),
      .gaze_left_x     (rsp_ch.gaze_left_x),
      .gaze_left_y     (rsp_ch.gaze_left_y),
      .right_magnitude (rsp_ch.right_magnitude),
      .left_magnitude  (rsp_ch.left_magnitude),
      .right_blinks    (rsp_ch.right_blinks),
      .left_blinks     (rsp_ch.left_blinks),
      .eyes_ok         (rsp_ch.eyes_ok),
      .nose_ok         (rsp_ch.nose_ok),
      .mouth_ok        (rsp_ch.mouth_ok)
   );

endmodule

`default_nettype wire
